@@ design/crsf_pkg.sv @@
// Shared types, constants and the CRC-8 step for the CRSF frame parser.
package crsf_pkg;

    localparam logic [7:0] CRC_POLY       = 8'hD5;
    localparam int         PAYLOAD_BYTES  = 22;
    localparam int         CHAN_BITS      = 11;
    localparam int         MIN_LEN        = 2;
    localparam logic [7:0] CHAN_FRAME_LEN = 8'(PAYLOAD_BYTES + 2);
    localparam int         ACC_W          = CHAN_BITS + 8;
    localparam int         NBITS_W        = 5;
    localparam int         CH_W           = 4;
    localparam int         CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 1'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic len_load;
        logic data_store;
        logic unpack_start;
        logic read_issue;
        logic acc_load;
        logic emit;
    } crsf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_sync;
        logic len_ok;
        logic last_byte;
        logic frame_good;
        logic nbits_ge;
        logic last_ch;
        logic out_free;
    } crsf_sts_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ design/crsf_ctrl.sv @@
// Controller state machine of the CRSF frame parser.
module crsf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    output logic                data_ready,
    input  crsf_pkg::crsf_sts_t sts,
    output crsf_pkg::crsf_cmd_t cmd
);
    import crsf_pkg::*;

    localparam logic [2:0] S_SYNC = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_DATA = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       fire;

    assign data_ready = (state_reg == S_SYNC) || (state_reg == S_LEN) ||
                        (state_reg == S_DATA);
    assign fire = data_valid && data_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_SYNC:
            begin
                if (fire && sts.is_sync)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                if (fire)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.len_load = 1'b1;
                        state_next   = S_DATA;
                    end
                    else
                        state_next = S_SYNC;
                end
            end
            S_DATA:
            begin
                if (fire)
                begin
                    cmd.data_store = 1'b1;
                    if (sts.last_byte)
                    begin
                        if (sts.frame_good)
                        begin
                            cmd.unpack_start = 1'b1;
                            state_next       = S_READ;
                        end
                        else
                            state_next = S_SYNC;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.acc_load = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!sts.nbits_ge)
                    state_next = S_READ;
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_ch)
                        state_next = S_SYNC;
                end
            end
            default:
            begin
                state_next = S_SYNC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_SYNC;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/crsf_dp.sv @@
// Datapath of the CRSF frame parser: frame store, CRC, unpacker, output register.
module crsf_dp #(
    parameter int BUFFER_BYTES = 64,
    parameter int CHANNELS     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic [7:0]                          data_byte,
    input  crsf_pkg::crsf_cmd_t                 cmd,
    output crsf_pkg::crsf_sts_t                 sts,
    output logic                                chan_valid,
    input  logic                                chan_ready,
    output logic [crsf_pkg::CH_W-1:0]           channel_index,
    output logic [crsf_pkg::CHAN_BITS-1:0]      channel_value,
    output logic                                last_channel
);
    import crsf_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]         sync_byte_reg;
    logic [7:0]         frame_type_reg;
    logic [7:0]         frame_length_reg;
    logic [7:0]         byte_count_reg;
    logic [7:0]         crc_reg;
    logic [7:0]         type_reg;
    logic [7:0]         frame_store [BUFFER_BYTES];
    logic [7:0]         rd_data_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [NBITS_W-1:0] nbits_reg;
    logic [CH_W-1:0]    ch_reg;
    logic               chan_valid_reg;
    logic [CH_W-1:0]    channel_index_reg;
    logic [CHAN_BITS-1:0] channel_value_reg;
    logic               last_channel_reg;
    logic [8:0]         count_plus;

    assign count_plus = {1'b0, byte_count_reg} + 9'd1;

    assign sts.is_sync    = (data_byte == sync_byte_reg);
    assign sts.len_ok     = (data_byte >= 8'(MIN_LEN)) && (data_byte <= 8'(BUFFER_BYTES));
    assign sts.last_byte  = (count_plus >= {1'b0, frame_length_reg});
    assign sts.frame_good = (data_byte == crc_reg) && (type_reg == frame_type_reg) &&
                            (frame_length_reg == CHAN_FRAME_LEN);
    assign sts.nbits_ge   = (nbits_reg >= NBITS_W'(CHAN_BITS));
    assign sts.last_ch    = (ch_reg == CH_W'(CHANNELS - 1));
    assign sts.out_free   = !chan_valid_reg || chan_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg  <= 8'hC8;
            frame_type_reg <= 8'h16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_BYTE:  sync_byte_reg  <= cfg_data;
                CFG_FRAME_TYPE: frame_type_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame tracking and CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            crc_reg          <= '0;
        end
        else if (cmd.len_load)
        begin
            frame_length_reg <= data_byte;
            byte_count_reg   <= '0;
            crc_reg          <= '0;
        end
        else if (cmd.data_store)
        begin
            byte_count_reg <= count_plus[7:0];
            if (!sts.last_byte)
                crc_reg <= crc8_update(crc_reg, data_byte);
        end
    end

    // Frame store and the type byte copy
    always_ff @(posedge clk)
    begin
        if (cmd.data_store)
        begin
            frame_store[byte_count_reg[AW-1:0]] <= data_byte;
            if (byte_count_reg == 8'd0)
                type_reg <= data_byte;
        end
        if (cmd.read_issue)
            rd_data_reg <= frame_store[rd_ptr_reg];
    end

    // Unpacker: collect payload bytes LSB first, peel off 11-bit values
    always_ff @(posedge clk)
    begin
        if (cmd.unpack_start)
        begin
            acc_reg    <= '0;
            nbits_reg  <= '0;
            ch_reg     <= '0;
            rd_ptr_reg <= AW'(1);
        end
        else if (cmd.acc_load)
        begin
            acc_reg    <= acc_reg | (ACC_W'(rd_data_reg) << nbits_reg);
            nbits_reg  <= nbits_reg + NBITS_W'(8);
            rd_ptr_reg <= rd_ptr_reg + AW'(1);
        end
        else if (cmd.emit)
        begin
            acc_reg   <= acc_reg >> CHAN_BITS;
            nbits_reg <= nbits_reg - NBITS_W'(CHAN_BITS);
            ch_reg    <= ch_reg + CH_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chan_valid_reg <= 1'b0;
        else if (cmd.emit)
            chan_valid_reg <= 1'b1;
        else if (chan_ready)
            chan_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            channel_index_reg <= ch_reg;
            channel_value_reg <= acc_reg[CHAN_BITS-1:0];
            last_channel_reg  <= sts.last_ch;
        end
    end

    assign chan_valid    = chan_valid_reg;
    assign channel_index = channel_index_reg;
    assign channel_value = channel_value_reg;
    assign last_channel  = last_channel_reg;

endmodule

@@ design/crsf_frame_parser.sv @@
// Top level of the CRSF frame parser: controller plus datapath.
//
//  Channel   Signals                                        Direction
//  -------   ---------------------------------------------  ---------
//  byte in   data_valid, data_ready, data_byte              in
//  channels  chan_valid, chan_ready, channel_index,         out
//            channel_value, last_channel
//  config    cfg_we, cfg_index, cfg_data                    in
//
// Flow: one byte word is taken per cycle while data_valid is high during parsing
// (sync, length, frame bytes). After a good channels frame the input is held
// off while the unpacker reads the payload out of the frame store: for each
// byte a memory read, an accumulate and a check for enough bits (no check
// follows the last byte), and a separate step to emit each channel; the
// unpack waits when the output side stalls.
// Reset: rst_n is asynchronous, active low; it returns the parser to sync
// hunting, empties the output register and loads the default sync and type.
// Stalls: a finished channel word sits in the output register; the parser
// takes new bytes as soon as the last channel word of a frame is loaded.
module crsf_frame_parser #(
    parameter int BUFFER_BYTES = 64,
    parameter int CHANNELS     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                data_valid,
    output logic                                data_ready,
    input  logic [7:0]                          data_byte,
    output logic                                chan_valid,
    input  logic                                chan_ready,
    output logic [crsf_pkg::CH_W-1:0]           channel_index,
    output logic [crsf_pkg::CHAN_BITS-1:0]      channel_value,
    output logic                                last_channel
);
    import crsf_pkg::*;

    crsf_cmd_t cmd;
    crsf_sts_t sts;

    // Sequence the parse phases and the unpack burst
    crsf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Hold frame bytes, run the CRC, unpack channels into the output register
    crsf_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CHANNELS     (CHANNELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .sts           (sts),
        .chan_valid    (chan_valid),
        .chan_ready    (chan_ready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

endmodule
